>>> sv/vab_pkg.sv
// Shared types, constants and the arctangent table of the vector angle unit.
`timescale 1ns / 1ps
package vab_pkg;

  localparam int unsigned NORM_W = 30;  // normalized magnitude width
  localparam int unsigned SQ_W   = 62;  // sum of three squares
  localparam int unsigned ROOT_W = 31;  // integer square root
  localparam int unsigned REM_W  = 34;  // root remainder
  localparam int unsigned XY_W   = 34;  // rotator datapath
  localparam int unsigned ACC_W  = 32;  // angle accumulator, Q3.28

  localparam logic signed [ACC_W-1:0] ACC_PI      = 32'sd843314857;
  localparam logic signed [ACC_W-1:0] ACC_HALF_PI = 32'sd421657428;

  typedef struct packed {
    logic              zero;
    logic              neg;
    logic [NORM_W-1:0] ud;
  } side_t;

  // atan(2^-i) in Q3.28, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_q28(input int i);
    logic signed [ACC_W-1:0] v;
    case (i)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      24: v = 32'sd16;
      25: v = 32'sd8;
      26: v = 32'sd4;
      27: v = 32'sd2;
      28: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/vab_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module vab_isqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [vab_pkg::SQ_W-1:0]          n_i,
  input  vab_pkg::side_t                    side_i,
  output logic                              vld_o,
  output logic [vab_pkg::ROOT_W-1:0]        root_o,
  output vab_pkg::side_t                    side_o
);
  import vab_pkg::*;

  logic              vld_q  [ROOT_W+1];
  logic [SQ_W-1:0]   n_q    [ROOT_W+1];
  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  side_t             side_q [ROOT_W+1];

  always_comb begin
    vld_q[0]  = vld_i;
    n_q[0]    = n_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    side_q[0] = side_i;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem2;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;

    always_comb begin
      // bring down the next two bits and try a one in this root position
      rem2  = {rem_q[k][REM_W-3:0], n_q[k][SQ_W-1 -: 2]};
      trial = {1'b0, root_q[k], 2'b01};
      if (rem2 >= trial) begin
        rem_d  = rem2 - trial;
        root_d = {root_q[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem2;
        root_d = {root_q[k][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]    <= {n_q[k][SQ_W-3:0], 2'b00};
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W];
  assign root_o = root_q[ROOT_W];
  assign side_o = side_q[ROOT_W];

endmodule

>>> sv/vab_cordic.sv
// Pipelined vectoring rotator, one micro-rotation per stage.
`timescale 1ns / 1ps
module vab_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic [vab_pkg::ROOT_W-1:0]        r_i,
  input  vab_pkg::side_t                    side_i,
  output logic                              vld_o,
  output logic signed [vab_pkg::ACC_W-1:0]  acc_o,
  output vab_pkg::side_t                    side_o
);
  import vab_pkg::*;

  logic                    vld_q  [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  x_q    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  y_q    [CORDIC_STEPS+1];
  logic signed [ACC_W-1:0] acc_q  [CORDIC_STEPS+1];
  side_t                   side_q [CORDIC_STEPS+1];

  always_comb begin
    vld_q[0]  = vld_i;
    x_q[0]    = $signed({{(XY_W-NORM_W){1'b0}}, side_i.ud});
    y_q[0]    = $signed({{(XY_W-ROOT_W){1'b0}}, r_i});
    acc_q[0]  = '0;
    side_q[0] = side_i;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    // arithmetic shift floors negative values
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][XY_W-1]) begin
          x_q[i+1]   <= x_q[i] + ys;
          y_q[i+1]   <= y_q[i] - xs;
          acc_q[i+1] <= acc_q[i] + atan_q28(i);
        end else begin
          x_q[i+1]   <= x_q[i] - ys;
          y_q[i+1]   <= y_q[i] + xs;
          acc_q[i+1] <= acc_q[i] - atan_q28(i);
        end
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign vld_o  = vld_q[CORDIC_STEPS];
  assign acc_o  = acc_q[CORDIC_STEPS];
  assign side_o = side_q[CORDIC_STEPS];

endmodule

>>> sv/vec4_angle_between_unit.sv
// Top level of the vector angle unit: products, normalization, root and rotator.
`timescale 1ns / 1ps
// Angle between two 4-component signed fixed-point vectors, as
// atan2(|vec(conj(a)*b)|, a.b) in Q2.13 radians, 0 to pi. The pipeline takes one
// transaction per cycle while the output is not stalled and has no state between
// items. Its stages are product, sum, magnitude, maximum, leading-one, shift,
// square and square-sum, one stage per root bit, one stage per rotation, then the
// output register. When the output is stalled the whole pipeline holds.
module vec4_angle_between_unit #(
  parameter int unsigned COMPONENT_WIDTH = 16,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (lowest first)
  input  logic [8*COMPONENT_WIDTH-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // angle_rad [14:0], bit 15 is zero fill
  output logic [15:0]                  m_tdata
);
  import vab_pkg::*;

  localparam int unsigned W   = COMPONENT_WIDTH;
  localparam int unsigned SH  = (2 * W > 60) ? 2 * W - 60 : 0;
  localparam int unsigned PW  = 2 * W - SH;
  localparam int unsigned SW  = PW + 2;
  localparam int unsigned PSW = $clog2(SW);

  logic en;
  logic out_vld_q;
  logic [14:0] out_q;

  assign en       = !out_vld_q || m_tready;
  assign s_tready = en;

  logic signed [W-1:0] av [4];
  logic signed [W-1:0] bv [4];
  for (genvar c = 0; c < 4; c++) begin : g_unpack
    assign av[c] = s_tdata[c*W +: W];
    assign bv[c] = s_tdata[(c+4)*W +: W];
  end

  // stage 1: products a_i*b_j
  logic signed [PW-1:0] pr_q [4][4];
  logic v1_q;
  for (genvar i = 0; i < 4; i++) begin : g_pi
    for (genvar j = 0; j < 4; j++) begin : g_pj
      logic signed [2*W-1:0] full;
      logic signed [2*W-1:0] fsh;
      assign full = av[i] * bv[j];
      assign fsh  = full >>> SH;
      always_ff @(posedge clk_i) begin
        if (en) pr_q[i][j] <= fsh[PW-1:0];
      end
    end
  end

  // stage 2: cross terms and dot product
  logic signed [SW-1:0] sx_q, sy_q, sz_q, sd_q;
  logic v2_q;
  function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
    return {{2{p[PW-1]}}, p};
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= ext(pr_q[3][0]) - ext(pr_q[0][3]) - ext(pr_q[1][2]) + ext(pr_q[2][1]);
      sy_q <= ext(pr_q[3][1]) - ext(pr_q[1][3]) - ext(pr_q[2][0]) + ext(pr_q[0][2]);
      sz_q <= ext(pr_q[3][2]) - ext(pr_q[2][3]) - ext(pr_q[0][1]) + ext(pr_q[1][0]);
      sd_q <= ext(pr_q[0][0]) + ext(pr_q[1][1]) + ext(pr_q[2][2]) + ext(pr_q[3][3]);
    end
  end

  // stage 3: magnitudes
  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  logic [SW-1:0] ux_q, uy_q, uz_q, ud_q;
  logic neg3_q;
  logic v3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q   <= mag(sx_q);
      uy_q   <= mag(sy_q);
      uz_q   <= mag(sz_q);
      ud_q   <= mag(sd_q);
      neg3_q <= sd_q[SW-1];
    end
  end

  // stage 4: largest magnitude
  logic [SW-1:0] m4, mxy, mzd;
  logic [SW-1:0] ux4_q, uy4_q, uz4_q, ud4_q, m4_q;
  logic neg4_q;
  logic v4_q;
  assign mxy = (uy_q > ux_q) ? uy_q : ux_q;
  assign mzd = (ud_q > uz_q) ? ud_q : uz_q;
  assign m4  = (mzd > mxy) ? mzd : mxy;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ux4_q  <= ux_q;
      uy4_q  <= uy_q;
      uz4_q  <= uz_q;
      ud4_q  <= ud_q;
      m4_q   <= m4;
      neg4_q <= neg3_q;
    end
  end

  // stage 5: leading-one position
  logic [PSW-1:0] pos5;
  always_comb begin
    pos5 = '0;
    for (int b = 0; b < SW; b++) begin
      if (m4_q[b]) pos5 = PSW'(b);
    end
  end

  logic [SW-1:0] ux5_q, uy5_q, uz5_q, ud5_q;
  logic [PSW-1:0] pos5_q;
  logic neg5_q, zero5_q;
  logic v5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ux5_q   <= ux4_q;
      uy5_q   <= uy4_q;
      uz5_q   <= uz4_q;
      ud5_q   <= ud4_q;
      pos5_q  <= pos5;
      neg5_q  <= neg4_q;
      zero5_q <= (m4_q == '0);
    end
  end

  // stage 6: common shift that puts the largest one in bit 29
  function automatic logic [NORM_W-1:0] norm(input logic [SW-1:0] u,
                                             input logic [PSW-1:0] p);
    logic [SW+NORM_W-1:0] e;
    logic [SW+NORM_W-1:0] r;
    e = {{NORM_W{1'b0}}, u};
    if (32'(p) >= NORM_W - 1) r = e >> (32'(p) - (NORM_W - 1));
    else                      r = e << ((NORM_W - 1) - 32'(p));
    return r[NORM_W-1:0];
  endfunction

  logic [NORM_W-1:0] nx_q, ny_q, nz_q, nd_q;
  logic neg6_q, zero6_q;
  logic v6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q    <= norm(ux5_q, pos5_q);
      ny_q    <= norm(uy5_q, pos5_q);
      nz_q    <= norm(uz5_q, pos5_q);
      nd_q    <= norm(ud5_q, pos5_q);
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  // stage 7: squares
  logic [2*NORM_W-1:0] qx_q, qy_q, qz_q;
  logic [NORM_W-1:0] nd7_q;
  logic neg7_q, zero7_q;
  logic v7_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q    <= nx_q * nx_q;
      qy_q    <= ny_q * ny_q;
      qz_q    <= nz_q * nz_q;
      nd7_q   <= nd_q;
      neg7_q  <= neg6_q;
      zero7_q <= zero6_q;
    end
  end

  // stage 8: sum of squares
  logic [SQ_W-1:0] sq_q;
  side_t side8_q;
  logic v8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q         <= SQ_W'(qx_q) + SQ_W'(qy_q) + SQ_W'(qz_q);
      side8_q.ud   <= nd7_q;
      side8_q.neg  <= neg7_q;
      side8_q.zero <= zero7_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  logic              rt_vld;
  logic [ROOT_W-1:0] rt_root;
  side_t             rt_side;

  vab_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v8_q),
    .n_i    (sq_q),
    .side_i (side8_q),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .side_o (rt_side)
  );

  logic                    cr_vld;
  logic signed [ACC_W-1:0] cr_acc;
  side_t                   cr_side;

  vab_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (rt_vld),
    .r_i    (rt_root),
    .side_i (rt_side),
    .vld_o  (cr_vld),
    .acc_o  (cr_acc),
    .side_o (cr_side)
  );

  // clamp to the first quadrant, reflect for a negative dot product, round
  logic signed [ACC_W-1:0] acc_c;
  logic signed [ACC_W-1:0] acc_f;
  logic [ACC_W-1:0]        acc_r;
  always_comb begin
    acc_c = cr_acc;
    if (acc_c < 0)           acc_c = '0;
    if (acc_c > ACC_HALF_PI) acc_c = ACC_HALF_PI;
    acc_f = cr_side.neg ? ACC_PI - acc_c : acc_c;
    acc_r = unsigned'(acc_f) + ACC_W'(32'd16384);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= cr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= cr_side.zero ? 15'd0 : acc_r[29:15];
  end

  assign m_tvalid = out_vld_q;
  assign m_tdata  = {1'b0, out_q};

endmodule
